>>> hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Shared widths, register indexes, reset values and CORDIC constants.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int CORDIC_STEPS   = 17;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LA   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LA_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER = 3'd4;

    localparam logic [15:0] WHEELBASE_RST = 16'd2500;
    localparam logic [15:0] BASE_LA_RST   = 16'd2000;
    localparam logic [15:0] LA_GAIN_RST   = 16'd128;
    localparam logic [15:0] MAX_LA_RST    = 16'd8000;
    localparam logic [14:0] MAX_STEER_RST = 15'd4290;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [26:0] TWO_PI_Q16      = 27'sd411775;
    localparam logic signed [25:0] FORWARD_MIN_MM  = 26'sd20;

    function automatic logic [16:0] atan_entry(input logic [4:0] i);
        logic [16:0] v;
        begin
            case (i)
                5'd0:    v = 17'd51472;
                5'd1:    v = 17'd30385;
                5'd2:    v = 17'd16055;
                5'd3:    v = 17'd8150;
                5'd4:    v = 17'd4091;
                5'd5:    v = 17'd2047;
                5'd6:    v = 17'd1024;
                5'd7:    v = 17'd512;
                5'd8:    v = 17'd256;
                5'd9:    v = 17'd128;
                5'd10:   v = 17'd64;
                5'd11:   v = 17'd32;
                5'd12:   v = 17'd16;
                5'd13:   v = 17'd8;
                5'd14:   v = 17'd4;
                5'd15:   v = 17'd2;
                5'd16:   v = 17'd1;
                default: v = 17'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> hdl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering
// Streams path points, keeps the lookahead target and emits one steering
// command per path through a single shared multiplier and CORDIC sequencer.
// ----------------------------------------------------------------------------
// One point is in work at a time, and in_stall holds the input while a point is
// processed. A path's first point also sets up the lookahead and heading CORDIC,
// forward points are measured for distance, and points past the store limit
// skip the transform. A marked point then emits the command, with a forward
// target first going through setup, normalization, CORDIC and clamp steps.
// Reset returns the registers to their defaults and clears the path state.
module pure_pursuit_steering
#(
    parameter int MAX_POINTS = pps_pkg::MAX_POINTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [23:0]             pose_x,
    input  logic signed [23:0]             pose_y,
    input  logic [15:0]                    pose_heading,
    input  logic signed [15:0]             speed,
    input  logic signed [23:0]             point_x,
    input  logic signed [23:0]             point_y,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             steering,
    output logic [9:0]                     target_idx,
    output logic signed [23:0]             target_x,
    output logic signed [23:0]             target_y,
    output logic                           forward_found
);
    import pps_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LA0  = 5'd1;
    localparam logic [4:0] S_LA1  = 5'd2;
    localparam logic [4:0] S_LA2  = 5'd3;
    localparam logic [4:0] S_LA3  = 5'd4;
    localparam logic [4:0] S_HZ   = 5'd5;
    localparam logic [4:0] S_HC   = 5'd6;
    localparam logic [4:0] S_HF   = 5'd7;
    localparam logic [4:0] S_XF0  = 5'd8;
    localparam logic [4:0] S_XF1  = 5'd9;
    localparam logic [4:0] S_XF2  = 5'd10;
    localparam logic [4:0] S_XF3  = 5'd11;
    localparam logic [4:0] S_XF4  = 5'd12;
    localparam logic [4:0] S_SQ0  = 5'd13;
    localparam logic [4:0] S_SQ1  = 5'd14;
    localparam logic [4:0] S_SQ2  = 5'd15;
    localparam logic [4:0] S_SQ3  = 5'd16;
    localparam logic [4:0] S_POST = 5'd17;
    localparam logic [4:0] S_ST0  = 5'd18;
    localparam logic [4:0] S_ST1  = 5'd19;
    localparam logic [4:0] S_NRM  = 5'd20;
    localparam logic [4:0] S_CV   = 5'd21;
    localparam logic [4:0] S_STF  = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    logic [4:0]  state_reg, state_next;
    logic [4:0]  iter_reg;

    logic [15:0] wheelbase_reg, base_la_reg, la_gain_reg, max_la_reg;
    logic [14:0] max_steer_reg;

    logic signed [23:0] px_reg, py_reg, origin_x_reg, origin_y_reg;
    logic               last_reg;
    logic [14:0]        spd_reg;
    logic signed [15:0] ang_reg;
    logic               flip_reg;
    logic [15:0]        la_reg;
    logic [31:0]        reach_reg;
    logic signed [15:0] cos_reg, sin_reg;

    logic signed [33:0] hx_reg, hy_reg;
    logic signed [19:0] z_reg;

    logic signed [26:0] mul_a, mul_b;
    logic signed [53:0] prod_reg;
    logic signed [40:0] acc_reg;
    logic signed [25:0] lx_reg, ly_reg;
    logic [51:0]        sq_reg, d2_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   idx_reg, best_index_reg;
    logic               any_forward_reg, any_beyond_reg, any_selected_reg;
    logic [51:0]        best_d2_reg;
    logic signed [25:0] best_lat_reg;
    logic signed [23:0] best_x_reg, best_y_reg;

    logic signed [55:0] vx_reg, vy_reg;
    logic signed [16:0] st_reg;

    logic               out_valid_reg;
    logic signed [15:0] steering_reg;
    logic [9:0]         target_idx_reg;
    logic signed [23:0] target_x_reg, target_y_reg;
    logic               has_fwd_reg;

    logic               cnt_ok;
    logic               accept;
    logic               out_free;
    logic signed [24:0] dx, dy;
    logic signed [15:0] ang_in;
    logic [23:0]        la_sum;
    logic signed [33:0] zprod, zdiv;
    logic signed [40:0] acc_sum, acc_rnd;
    logic signed [33:0] cx_rnd, cy_rnd;
    logic [16:0]        atan_v;
    logic signed [55:0] vy_abs;
    logic signed [19:0] z_rnd;
    logic signed [16:0] st_raw, st_lim;
    logic               take, is_beyond;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_ok    = (cnt_reg < CNT_W'(MAX_POINTS));

    assign dx     = {px_reg[23], px_reg} - {origin_x_reg[23], origin_x_reg};
    assign dy     = {py_reg[23], py_reg} - {origin_y_reg[23], origin_y_reg};
    assign ang_in = $signed(pose_heading);
    assign atan_v = atan_entry(iter_reg);

    assign la_sum = {8'd0, base_la_reg} + 24'(prod_reg[31:8]);
    assign zprod  = prod_reg[33:0];
    assign zdiv   = zprod[33] ? -((-zprod) >>> 16) : (zprod >>> 16);
    assign acc_sum = acc_reg + 41'(prod_reg);
    assign cx_rnd = (hx_reg + 34'sd32768) >>> 16;
    assign cy_rnd = (hy_reg + 34'sd32768) >>> 16;
    assign vy_abs = vy_reg[55] ? -vy_reg : vy_reg;
    assign z_rnd  = (z_reg + 20'sd4) >>> 3;
    assign st_raw = z_rnd[16:0];
    assign st_lim = $signed({2'b00, max_steer_reg});

    always_comb
    begin
        if (state_reg == S_XF2)
        begin
            acc_rnd = (acc_sum + 41'sd8192) >>> 14;
        end
        else
        begin
            acc_rnd = (acc_reg - 41'(prod_reg) + 41'sd8192) >>> 14;
        end
    end

    always_comb
    begin
        is_beyond = (d2_reg >= {20'd0, reach_reg});
        take      = 1'b0;
        if (is_beyond)
        begin
            take = !any_beyond_reg || (d2_reg < best_d2_reg);
        end
        else
        begin
            take = !any_beyond_reg && (!any_selected_reg || (d2_reg > best_d2_reg));
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LA0:
            begin
                mul_a = {11'd0, la_gain_reg};
                mul_b = {12'd0, spd_reg};
            end
            S_LA2:
            begin
                mul_a = {11'd0, la_reg};
                mul_b = {11'd0, la_reg};
            end
            S_LA3:
            begin
                mul_a = {{11{ang_reg[15]}}, ang_reg};
                mul_b = TWO_PI_Q16;
            end
            S_XF0:
            begin
                mul_a = {{11{cos_reg[15]}}, cos_reg};
                mul_b = {{2{dx[24]}}, dx};
            end
            S_XF1:
            begin
                mul_a = {{11{sin_reg[15]}}, sin_reg};
                mul_b = {{2{dy[24]}}, dy};
            end
            S_XF2:
            begin
                mul_a = {{11{cos_reg[15]}}, cos_reg};
                mul_b = {{2{dy[24]}}, dy};
            end
            S_XF3:
            begin
                mul_a = {{11{sin_reg[15]}}, sin_reg};
                mul_b = {{2{dx[24]}}, dx};
            end
            S_SQ0:
            begin
                mul_a = {lx_reg[25], lx_reg};
                mul_b = {lx_reg[25], lx_reg};
            end
            S_SQ1:
            begin
                mul_a = {ly_reg[25], ly_reg};
                mul_b = {ly_reg[25], ly_reg};
            end
            S_ST0:
            begin
                mul_a = {11'd0, wheelbase_reg};
                mul_b = {best_lat_reg[25], best_lat_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = S_LA0;
                    end
                    else if (cnt_ok)
                    begin
                        state_next = S_XF0;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
            end
            S_LA0: state_next = S_LA1;
            S_LA1: state_next = S_LA2;
            S_LA2: state_next = S_LA3;
            S_LA3: state_next = S_HZ;
            S_HZ:  state_next = S_HC;
            S_HC:
            begin
                if (iter_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_HF;
                end
            end
            S_HF:  state_next = S_XF0;
            S_XF0: state_next = S_XF1;
            S_XF1: state_next = S_XF2;
            S_XF2: state_next = S_XF3;
            S_XF3: state_next = S_XF4;
            S_XF4: state_next = (lx_reg > FORWARD_MIN_MM) ? S_SQ0 : S_POST;
            S_SQ0: state_next = S_SQ1;
            S_SQ1: state_next = S_SQ2;
            S_SQ2: state_next = S_SQ3;
            S_SQ3: state_next = S_POST;
            S_POST:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (any_forward_reg)
                begin
                    state_next = S_ST0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_ST0: state_next = S_ST1;
            S_ST1: state_next = S_NRM;
            S_NRM:
            begin
                if ((vx_reg[55:50] != 6'd0) || (vy_abs[55:50] != 6'd0))
                begin
                    state_next = S_CV;
                end
            end
            S_CV:
            begin
                if (iter_reg == 5'(CORDIC_STEPS - 1))
                begin
                    state_next = S_STF;
                end
            end
            S_STF: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wheelbase_reg    <= WHEELBASE_RST;
            base_la_reg      <= BASE_LA_RST;
            la_gain_reg      <= LA_GAIN_RST;
            max_la_reg       <= MAX_LA_RST;
            max_steer_reg    <= MAX_STEER_RST;
            cnt_reg          <= '0;
            any_forward_reg  <= 1'b0;
            any_beyond_reg   <= 1'b0;
            any_selected_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WHEELBASE: wheelbase_reg <= cfg_data;
                    REG_BASE_LA:   base_la_reg   <= cfg_data;
                    REG_LA_GAIN:   la_gain_reg   <= cfg_data;
                    REG_MAX_LA:    max_la_reg    <= cfg_data;
                    REG_MAX_STEER: max_steer_reg <= cfg_data[14:0];
                    default:       ;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == S_SQ3) && take)
            begin
                any_selected_reg <= 1'b1;
            end
            if (state_reg == S_SQ3)
            begin
                any_forward_reg <= 1'b1;
                if (take && is_beyond)
                begin
                    any_beyond_reg <= 1'b1;
                end
            end
            if ((state_reg == S_POST) && cnt_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg    <= 1'b1;
                cnt_reg          <= '0;
                any_forward_reg  <= 1'b0;
                any_beyond_reg   <= 1'b0;
                any_selected_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            last_reg <= last_point;
            if (cnt_reg == '0)
            begin
                origin_x_reg <= pose_x;
                origin_y_reg <= pose_y;
                spd_reg      <= speed[15] ? 15'd0 : speed[14:0];
                if (ang_in > 16'sd16384)
                begin
                    ang_reg  <= ang_in - 16'sd32767 - 16'sd1;
                    flip_reg <= 1'b1;
                end
                else if (ang_in < -16'sd16384)
                begin
                    ang_reg  <= ang_in + 16'sd32767 + 16'sd1;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    ang_reg  <= ang_in;
                    flip_reg <= 1'b0;
                end
            end
        end
        case (state_reg)
            S_LA1:
            begin
                la_reg <= (la_sum > {8'd0, max_la_reg}) ? max_la_reg : la_sum[15:0];
            end
            S_LA3:
            begin
                reach_reg <= prod_reg[31:0];
            end
            S_HZ:
            begin
                z_reg    <= zdiv[19:0];
                hx_reg   <= CORDIC_GAIN_Q30;
                hy_reg   <= '0;
                iter_reg <= '0;
            end
            S_HC:
            begin
                if (!z_reg[19])
                begin
                    hx_reg <= hx_reg - (hy_reg >>> iter_reg);
                    hy_reg <= hy_reg + (hx_reg >>> iter_reg);
                    z_reg  <= z_reg - $signed({3'd0, atan_v});
                end
                else
                begin
                    hx_reg <= hx_reg + (hy_reg >>> iter_reg);
                    hy_reg <= hy_reg - (hx_reg >>> iter_reg);
                    z_reg  <= z_reg + $signed({3'd0, atan_v});
                end
                iter_reg <= iter_reg + 1'b1;
            end
            S_HF:
            begin
                cos_reg <= flip_reg ? -cx_rnd[15:0] : cx_rnd[15:0];
                sin_reg <= flip_reg ? -cy_rnd[15:0] : cy_rnd[15:0];
            end
            S_XF1:
            begin
                acc_reg <= 41'(prod_reg);
            end
            S_XF2:
            begin
                lx_reg <= acc_rnd[25:0];
            end
            S_XF3:
            begin
                acc_reg <= 41'(prod_reg);
            end
            S_XF4:
            begin
                ly_reg <= acc_rnd[25:0];
            end
            S_SQ1:
            begin
                sq_reg <= prod_reg[51:0];
            end
            S_SQ2:
            begin
                d2_reg <= sq_reg + prod_reg[51:0];
            end
            S_SQ3:
            begin
                if (take)
                begin
                    best_d2_reg    <= d2_reg;
                    best_lat_reg   <= ly_reg;
                    best_index_reg <= cnt_reg[IDX_W-1:0];
                    best_x_reg     <= px_reg;
                    best_y_reg     <= py_reg;
                end
            end
            S_POST:
            begin
                idx_reg <= cnt_ok ? cnt_reg[IDX_W-1:0] : IDX_W'(MAX_POINTS - 1);
            end
            S_ST1:
            begin
                vx_reg <= (best_d2_reg == '0) ? 56'sd1 : $signed({4'd0, best_d2_reg});
                vy_reg <= {prod_reg[53], prod_reg[53:0], 1'b0};
                z_reg  <= '0;
            end
            S_NRM:
            begin
                if ((vx_reg[55:50] == 6'd0) && (vy_abs[55:50] == 6'd0))
                begin
                    vx_reg <= vx_reg <<< 1;
                    vy_reg <= vy_reg <<< 1;
                end
                iter_reg <= '0;
            end
            S_CV:
            begin
                if (!vy_reg[55])
                begin
                    vx_reg <= vx_reg + (vy_reg >>> iter_reg);
                    vy_reg <= vy_reg - (vx_reg >>> iter_reg);
                    z_reg  <= z_reg + $signed({3'd0, atan_v});
                end
                else
                begin
                    vx_reg <= vx_reg - (vy_reg >>> iter_reg);
                    vy_reg <= vy_reg + (vx_reg >>> iter_reg);
                    z_reg  <= z_reg - $signed({3'd0, atan_v});
                end
                iter_reg <= iter_reg + 1'b1;
            end
            S_STF:
            begin
                if (st_raw > st_lim)
                begin
                    st_reg <= st_lim;
                end
                else if (st_raw < -st_lim)
                begin
                    st_reg <= -st_lim;
                end
                else
                begin
                    st_reg <= st_raw;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (any_forward_reg)
                    begin
                        steering_reg   <= st_reg[15:0];
                        target_idx_reg <= 10'(best_index_reg);
                        target_x_reg   <= best_x_reg;
                        target_y_reg   <= best_y_reg;
                        has_fwd_reg    <= 1'b1;
                    end
                    else
                    begin
                        steering_reg   <= '0;
                        target_idx_reg <= 10'(idx_reg);
                        target_x_reg   <= px_reg;
                        target_y_reg   <= py_reg;
                        has_fwd_reg    <= 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign steering      = steering_reg;
    assign target_idx    = target_idx_reg;
    assign target_x      = target_x_reg;
    assign target_y      = target_y_reg;
    assign forward_found = has_fwd_reg;

endmodule
